// ----- hdl/dpdr_pkg.sv -----
// Shared types, codes and helper functions of the page descriptor rank block.
`timescale 1ns / 1ps

package dpdr_pkg;

  // Input word opcodes.
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_APPEND    = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_DUMP = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_SHIFT  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_OFFSET = 8'd1;

  // Page shift limits.
  localparam logic [4:0] SHIFT_MIN = 5'd9;
  localparam logic [4:0] SHIFT_MAX = 5'd16;
  localparam logic [4:0] SHIFT_RST = 5'd12;

  localparam int unsigned CountW = 21;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] bitmap_word;
    logic [63:0] address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [54:0]       page_frame;
    logic [15:0]       page_byte;
    logic [CountW-1:0] desc_index;
    logic [63:0]       desc_offset;
  } out_word_t;

  // What the rank unit hands back for one lookup.
  typedef struct packed {
    logic              dumpable;
    logic [CountW-1:0] rank;
    logic [63:0]       offset;
  } rank_res_t;

  // Number of set bits in a 64-bit word.
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int k = 0; k < 64; k++) begin
      n = n + {6'd0, v[k]};
    end
    return n;
  endfunction

endpackage

// ----- hdl/dpdr_store.sv -----
// Bitmap word and prefix count memories with one write and one read port.
`timescale 1ns / 1ps

module dpdr_store
  import dpdr_pkg::*;
#(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = 14
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [63:0]       wr_word_i,
  input  logic [CountW-1:0] wr_prefix_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [63:0]       rd_word_o,
  output logic [CountW-1:0] rd_prefix_o
);

  logic [63:0]       word_mem   [Depth];
  logic [CountW-1:0] prefix_mem [Depth];

  logic [63:0]       rd_word_q;
  logic [CountW-1:0] rd_prefix_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      word_mem[wr_addr_i]   <= wr_word_i;
      prefix_mem[wr_addr_i] <= wr_prefix_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q   <= word_mem[rd_addr_i];
      rd_prefix_q <= prefix_mem[rd_addr_i];
    end
  end

  assign rd_word_o   = rd_word_q;
  assign rd_prefix_o = rd_prefix_q;

endmodule

// ----- hdl/dpdr_rank.sv -----
// Two-stage rank unit: masked popcount plus prefix, then descriptor offset.
`timescale 1ns / 1ps

module dpdr_rank
  import dpdr_pkg::*;
#(
  parameter int unsigned DescBytes = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       word_i,
  input  logic [CountW-1:0] prefix_i,
  input  logic [5:0]        bit_i,
  input  logic [62:0]       data_offset_i,
  output logic              done_o,
  output rank_res_t         res_o
);

  localparam int unsigned DbW   = $clog2(DescBytes + 1);
  localparam int unsigned ProdW = CountW + 1 + DbW + 1;

  logic              s1_valid_q, s2_valid_q;
  logic              s1_dump_q;
  logic [CountW-1:0] s1_rank_q;
  rank_res_t         s2_res_q;

  logic [63:0]              sel_mask;
  logic [6:0]               pop;
  logic signed [CountW:0]   rank_m1;
  logic signed [DbW:0]      db_s;
  logic signed [ProdW-1:0]  prod;
  logic [63:0]              prod_ext;

  // Stage one: count the set bits up to and including the frame's bit.
  assign sel_mask = 64'hFFFF_FFFF_FFFF_FFFF >> (6'd63 - bit_i);
  assign pop      = popcount64(word_i & sel_mask);

  // Stage two: (rank - 1) times the descriptor size, modulo 2^64.
  assign rank_m1  = $signed({1'b0, s1_rank_q}) - $signed((CountW + 1)'(1));
  assign db_s     = $signed({1'b0, DbW'(DescBytes)});
  assign prod     = ProdW'(rank_m1) * ProdW'(db_s);
  assign prod_ext = {{(64 - ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_rank_q <= prefix_i + CountW'(pop);
      s1_dump_q <= word_i[bit_i];
    end
    if (s1_valid_q) begin
      s2_res_q.dumpable <= s1_dump_q;
      s2_res_q.rank     <= s1_rank_q;
      s2_res_q.offset   <= {1'b0, data_offset_i} + prod_ext;
    end
  end

  assign done_o = s2_valid_q;
  assign res_o  = s2_res_q;

endmodule

// ----- hdl/dump_page_descriptor_rank.sv -----
// Top level of the page descriptor rank block for compressed crash dumps.
`timescale 1ns / 1ps

// Loads a dump's page bitmap one 64-bit word per append and translates
// physical addresses into page descriptor indexes and file offsets. One
// word is processed at a time: a clear, an append or a translate that
// misses the loaded bitmap goes from execution straight to its result,
// while a translate that hits it passes first the memory read of the
// bitmap word and its prefix count, then the two-stage rank unit
// (popcount and prefix add, then the descriptor offset multiply).
// The next word is accepted as soon as the current result sits in the
// output register, even while that result waits to be taken. Memory
// contents need no clearing after reset; only entries below the loaded
// word count are ever read.
module dump_page_descriptor_rank
  import dpdr_pkg::*;
#(
  parameter int unsigned BITMAP_WORDS = 16384,
  parameter int unsigned DESC_BYTES   = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned AddrW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned WlW   = $clog2(BITMAP_WORDS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_RANK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [4:0]        page_shift_q;
  logic [62:0]       data_offset_q;
  logic [WlW-1:0]    words_q, words_d;
  logic [CountW-1:0] count_q, count_d;
  in_word_t          in_q;
  out_word_t         res_q, res_d;
  out_word_t         out_q;
  logic              out_valid_q;
  logic [54:0]       frame_q;

  logic              in_fire, out_load;
  logic [4:0]        shift_eff;
  logic [63:0]       addr_shifted;
  logic [54:0]       frame;
  logic [48:0]       word_idx;
  logic              beyond, full;
  logic              wr_en, rd_en;
  logic [63:0]       rd_word;
  logic [CountW-1:0] rd_prefix;
  logic              rank_start, rank_done;
  rank_res_t         rank_res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Configuration registers; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= SHIFT_RST;
      data_offset_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PAGE_SHIFT) begin
        page_shift_q <= cfg_data_i[4:0];
      end else if (cfg_index_i == CFG_DATA_OFFSET) begin
        data_offset_q <= cfg_data_i[62:0];
      end
    end
  end

  // Address split with the page shift clamped to the supported range.
  always_comb begin
    if (page_shift_q < SHIFT_MIN) begin
      shift_eff = SHIFT_MIN;
    end else if (page_shift_q > SHIFT_MAX) begin
      shift_eff = SHIFT_MAX;
    end else begin
      shift_eff = page_shift_q;
    end
  end

  assign addr_shifted = in_q.address >> shift_eff;
  assign frame        = addr_shifted[54:0];
  assign word_idx     = frame[54:6];
  assign beyond       = word_idx >= 49'(words_q);
  assign full         = words_q == WlW'(BITMAP_WORDS);

  // Sequencer for one word at a time.
  always_comb begin
    state_d    = state_q;
    words_d    = words_q;
    count_d    = count_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rank_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_DONE;
        case (in_q.opcode)
          OP_CLEAR: begin
            words_d = '0;
            count_d = '0;
          end
          OP_APPEND: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              words_d = words_q + WlW'(1);
              count_d = count_q + CountW'(popcount64(in_q.bitmap_word));
            end
          end
          OP_TRANSLATE: begin
            res_d.page_frame = frame;
            res_d.page_byte  = in_q.address[15:0] & (16'hFFFF >> (5'd16 - shift_eff));
            if (beyond) begin
              res_d.status = ST_BEYOND;
            end else begin
              rd_en   = 1'b1;
              state_d = S_READ;
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
      S_READ: begin
        rank_start = 1'b1;
        state_d    = S_RANK;
      end
      S_RANK: begin
        if (rank_done) begin
          res_d.desc_index = rank_res.rank;
          if (rank_res.dumpable) begin
            res_d.status      = ST_OK;
            res_d.desc_offset = rank_res.offset;
          end else begin
            res_d.status      = ST_NOT_DUMP;
            res_d.desc_offset = '0;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      words_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      words_q <= words_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_word_i;
    end
    if (rd_en) begin
      frame_q <= frame;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  dpdr_store #(
    .Depth (BITMAP_WORDS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (words_q[AddrW-1:0]),
    .wr_word_i   (in_q.bitmap_word),
    .wr_prefix_i (count_q),
    .rd_en_i     (rd_en),
    .rd_addr_i   (word_idx[AddrW-1:0]),
    .rd_word_o   (rd_word),
    .rd_prefix_o (rd_prefix)
  );

  dpdr_rank #(
    .DescBytes (DESC_BYTES)
  ) u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (rank_start),
    .word_i        (rd_word),
    .prefix_i      (rd_prefix),
    .bit_i         (frame_q[5:0]),
    .data_offset_i (data_offset_q),
    .done_o        (rank_done),
    .res_o         (rank_res)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench of the page descriptor rank block, scored word by word against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import dpdr_pkg::*;

  localparam int unsigned MapWords    = 16384;
  localparam int unsigned DescBytes   = 24;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandItems   = 2000;
  localparam int unsigned NumSettings = 8;
  localparam int unsigned ErrShow     = 40;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [62:0] OffsetMax   = '1;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // One queued input word, optionally with its result written out by hand.
  typedef struct packed {
    in_word_t  stim;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  localparam out_word_t ZERO_WORD  = '0;
  localparam out_word_t STORE_FULL = '{ST_FULL, 55'd0, 16'd0, 21'd0, 64'd0};

  // Directed words, run with the reset configuration (4 KiB pages, offset zero).
  localparam int unsigned DirRows = 23;
  localparam stim_row_t DIR_TABLE [DirRows] = '{
    '{'{OP_TRANSLATE, 64'd0, 64'd0}, 1'b1, '{ST_BEYOND, 55'd0, 16'd0, 21'd0, 64'd0}},
    '{'{OP_TRANSLATE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{ST_BEYOND, 55'h000F_FFFF_FFFF_FFFF, 16'h0FFF, 21'd0, 64'd0}},
    '{'{OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, ZERO_WORD},
    '{'{OP_APPEND, 64'd0, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_APPEND, 64'h8000_0000_0000_0001, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_APPEND, 64'hA5A5_A5A5_A5A5_A5A5, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0000_0ABC}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0004_0000}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0007_FFFF}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0008_0000}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0008_1000}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_000B_F000}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_000C_0000}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_000F_F123}, 1'b0, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0010_0000}, 1'b1,
      '{ST_BEYOND, 55'd256, 16'd0, 21'd0, 64'd0}},
    '{'{OP_TRANSLATE, 64'd0, 64'h8000_0000_0004_0123}, 1'b0, ZERO_WORD},
    '{'{OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0004_0000}, 1'b1,
      '{ST_BEYOND, 55'd64, 16'd0, 21'd0, 64'd0}},
    '{'{OP_APPEND, 64'h0000_0000_0000_0002, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0000_1FFF}, 1'b0, ZERO_WORD},
    '{'{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 1'b1, ZERO_WORD},
    '{'{OP_TRANSLATE, 64'd0, 64'h0000_0000_0007_F000}, 1'b0, ZERO_WORD}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_word_t           in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_data  = '0;

  // Predictor state: loaded bitmap words, their prefix counts and the registers.
  logic [63:0]       map_word   [MapWords];
  logic [CountW-1:0] map_prefix [MapWords];
  int unsigned       map_used   = 0;
  logic [CountW-1:0] map_total  = '0;
  logic [4:0]        shift_cfg  = SHIFT_RST;
  logic [62:0]       base_cfg   = '0;

  stim_row_t   pending_lookups [$];
  out_word_t   expected_desc [$];
  int unsigned gen_used     = 0;
  bit          offer_open   = 1'b0;
  idle_mode_e  idle_mode    = IDLE_NONE;
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;

  dump_page_descriptor_rank #(
    .BITMAP_WORDS(MapWords),
    .DESC_BYTES  (DescBytes)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Number of set bits, cleared one at a time from the bottom.
  function automatic logic [6:0] ones_in(logic [63:0] v);
    logic [63:0] rest;
    logic [6:0]  n;
    rest = v;
    n    = '0;
    while (rest != '0) begin
      rest &= rest - 64'd1;
      n++;
    end
    return n;
  endfunction

  // Page shift as the block uses it, held to the legal range.
  function automatic logic [4:0] eff_shift();
    if (shift_cfg < SHIFT_MIN) return SHIFT_MIN;
    if (shift_cfg > SHIFT_MAX) return SHIFT_MAX;
    return shift_cfg;
  endfunction

  // Percentage of cycles in which one side holds back in the current mode.
  function automatic int unsigned stall_pct(bit recv_side);
    case (idle_mode)
      IDLE_SEND: return recv_side ? 0 : 65;
      IDLE_RECV: return recv_side ? 65 : 0;
      IDLE_BOTH: return 8;
      default:   return 0;
    endcase
  endfunction

  // Expected result of one accepted word; updates the predictor state.
  function automatic out_word_t predict_descriptor(in_word_t w);
    out_word_t         r;
    logic [4:0]        sh;
    logic [63:0]       frame;
    logic [63:0]       word;
    logic [63:0]       upto;
    logic [5:0]        bpos;
    logic [CountW-1:0] rank;
    r = '0;
    case (w.opcode)
      OP_CLEAR: begin
        map_used  = 0;
        map_total = '0;
      end
      OP_APPEND: begin
        if (map_used >= MapWords) begin
          r.status = ST_FULL;
        end else begin
          map_word[map_used]   = w.bitmap_word;
          map_prefix[map_used] = map_total;
          map_total = map_total + CountW'(ones_in(w.bitmap_word));
          map_used++;
        end
      end
      OP_TRANSLATE: begin
        sh           = eff_shift();
        frame        = w.address >> sh;
        r.page_frame = frame[54:0];
        r.page_byte  = 16'(w.address & ((64'd1 << sh) - 64'd1));
        if ((frame >> 6) >= 64'(map_used)) begin
          r.status = ST_BEYOND;
        end else begin
          word = map_word[frame[19:6]];
          bpos = frame[5:0];
          // Mask of the bits up to and including the frame's own bit.
          upto = ~(64'hFFFF_FFFF_FFFF_FFFE << bpos);
          rank = map_prefix[frame[19:6]] + CountW'(ones_in(word & upto));
          r.desc_index = rank;
          if (word[bpos]) begin
            r.status      = ST_OK;
            r.desc_offset = {1'b0, base_cfg} + (64'(rank) - 64'd1) * 64'(DescBytes);
          end else begin
            r.status = ST_NOT_DUMP;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: offers the head of the queue, with random gaps between words.
  always @(negedge clk) begin
    if (!offer_open) begin
      if (rst_n && pending_lookups.size() != 0 &&
          $urandom_range(0, 99) >= stall_pct(1'b0)) begin
        in_valid   <= 1'b1;
        in_word    <= pending_lookups[0].stim;
        offer_open = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back pressure on the result channel.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct(1'b1));
  end

  // Scoreboard: check results in order, predict each accepted word.
  always @(posedge clk) begin : score
    out_word_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (expected_desc.size() == 0) begin
          err_count++;
          if (err_count <= ErrShow) $error("result word with no expectation waiting");
        end else begin
          want = expected_desc.pop_front();
          if (out_word.status !== want.status) begin
            err_count++;
            if (err_count <= ErrShow)
              $error("status: expected %0d, got %0d", want.status, out_word.status);
          end
          if (out_word.page_frame !== want.page_frame) begin
            err_count++;
            if (err_count <= ErrShow)
              $error("page_frame: expected %0h, got %0h", want.page_frame, out_word.page_frame);
          end
          if (out_word.page_byte !== want.page_byte) begin
            err_count++;
            if (err_count <= ErrShow)
              $error("page_byte: expected %0h, got %0h", want.page_byte, out_word.page_byte);
          end
          if (out_word.desc_index !== want.desc_index) begin
            err_count++;
            if (err_count <= ErrShow)
              $error("desc_index: expected %0d, got %0d", want.desc_index, out_word.desc_index);
          end
          if (out_word.desc_offset !== want.desc_offset) begin
            err_count++;
            if (err_count <= ErrShow)
              $error("desc_offset: expected %0h, got %0h", want.desc_offset,
                     out_word.desc_offset);
          end
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        offer_open   = 1'b0;
        want = predict_descriptor(pending_lookups[0].stim);
        if (pending_lookups[0].typed) want = pending_lookups[0].want;
        expected_desc.push_back(want);
        void'(pending_lookups.pop_front());
      end
      if (cfg_valid && cfg_ready) quiet_cycles = 0;
    end
  end

  // Queue one word for the sender and track how many words it will have loaded.
  task automatic queue_lookup(in_word_t w, logic typed = 1'b0, out_word_t want = '0);
    while (pending_lookups.size() >= 3) @(posedge clk);
    pending_lookups.push_back('{w, typed, want});
    if (w.opcode == OP_CLEAR) gen_used = 0;
    else if (w.opcode == OP_APPEND && gen_used < MapWords) gen_used++;
  endtask

  // Wait until the block has nothing left in flight.
  task automatic wait_drained();
    while (pending_lookups.size() != 0 || expected_desc.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PAGE_SHIFT) shift_cfg = data[4:0];
    else if (idx == CFG_DATA_OFFSET) base_cfg = data[62:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed load-then-translate sequences, with some raw noise.
  task automatic run_random(int unsigned budget);
    int unsigned done_items;
    int unsigned seq_no;
    int unsigned n;
    int unsigned limit_frame;
    logic [4:0]  sh;
    logic [63:0] frame;
    logic [63:0] one_hot;
    in_word_t    w;
    done_items = 0;
    seq_no     = 0;
    while (done_items < budget) begin
      seq_no++;
      // Now and then the sender holds off until every result is back.
      if (seq_no % 23 == 5) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        w.opcode      = 2'($urandom_range(0, 3));
        w.bitmap_word = {$urandom, $urandom};
        w.address     = {$urandom, $urandom};
        queue_lookup(w);
        if (w.opcode != OP_UNUSED) done_items++;
      end else begin
        if ($urandom_range(0, 9) != 0 || gen_used > 2000) begin
          w        = '0;
          w.opcode = OP_CLEAR;
          queue_lookup(w);
          done_items++;
        end
        // Load a short bitmap of mixed density.
        n = $urandom_range(1, 24);
        repeat (n) begin
          w        = '0;
          w.opcode = OP_APPEND;
          one_hot  = 64'd1 << $urandom_range(0, 63);
          case ($urandom_range(0, 5))
            0:       w.bitmap_word = '1;
            1:       w.bitmap_word = '0;
            2:       w.bitmap_word = one_hot;
            3:       w.bitmap_word = ~one_hot;
            4:       w.bitmap_word = {$urandom, $urandom} & {$urandom, $urandom};
            default: w.bitmap_word = {$urandom, $urandom};
          endcase
          queue_lookup(w);
          done_items++;
        end
        // Translate addresses mostly inside the loaded bitmap.
        n  = $urandom_range(2, 16);
        sh = eff_shift();
        repeat (n) begin
          limit_frame = gen_used * 64;
          if ($urandom_range(0, 7) == 0 || limit_frame == 0)
            frame = 64'(limit_frame + $urandom_range(0, 200));
          else
            frame = 64'($urandom_range(0, limit_frame - 1));
          w         = '0;
          w.opcode  = OP_TRANSLATE;
          w.address = (frame << sh) | ({$urandom, $urandom} & ((64'd1 << sh) - 64'd1));
          queue_lookup(w);
          done_items++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [63:0] sh_val;
    logic [63:0] off_val;
    in_word_t    w;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset configuration.
    for (int i = 0; i < DirRows; i++) begin
      queue_lookup(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    // Random phases, each with its own register setting and one of the idling modes.
    for (int p = 0; p < NumSettings; p++) begin
      idle_mode = idle_mode_e'(2'(p));
      case (p)
        0: begin sh_val = 64'(SHIFT_MIN); off_val = 64'd0; end
        1: begin sh_val = 64'(SHIFT_MAX); off_val = {1'b0, OffsetMax}; end
        2: begin sh_val = 64'd0; off_val = {$urandom, $urandom}; end
        3: begin sh_val = 64'd31; off_val = 64'hFFFF_FFFF_FFFF_FFFF; end
        4: begin sh_val = {$urandom, $urandom}; sh_val[4:0] = SHIFT_RST; off_val = 64'd0; end
        5: begin sh_val = {$urandom, $urandom}; off_val = {$urandom, $urandom}; end
        6: begin sh_val = 64'($urandom_range(9, 16)); off_val = {1'b0, OffsetMax}; end
        default: begin sh_val = 64'd13; off_val = {$urandom, $urandom}; end
      endcase
      write_reg(CFG_PAGE_SHIFT, sh_val);
      write_reg(CFG_DATA_OFFSET, off_val);
      run_random(RandItems / NumSettings);
    end

    // Fill the whole store with set bits, then push past its end.
    idle_mode = IDLE_NONE;
    write_reg(CFG_PAGE_SHIFT, 64'(SHIFT_MIN));
    write_reg(CFG_DATA_OFFSET, {1'b0, OffsetMax});
    w        = '0;
    w.opcode = OP_CLEAR;
    queue_lookup(w);
    w.opcode      = OP_APPEND;
    w.bitmap_word = '1;
    repeat (MapWords) queue_lookup(w);
    queue_lookup(w, 1'b1, STORE_FULL);
    w.bitmap_word = {$urandom, $urandom};
    queue_lookup(w, 1'b1, STORE_FULL);
    w         = '0;
    w.opcode  = OP_TRANSLATE;
    w.address = (64'(MapWords * 64 - 1) << SHIFT_MIN) | 64'h1FF;
    queue_lookup(w);
    w.address = 64'(MapWords * 64) << SHIFT_MIN;
    queue_lookup(w);
    idle_mode = IDLE_BOTH;
    repeat (40) begin
      w.address = (64'($urandom_range(0, MapWords * 64 - 1)) << SHIFT_MIN) |
                  64'($urandom_range(0, 511));
      queue_lookup(w);
    end

    // Largest pages over the full store, then start over.
    write_reg(CFG_PAGE_SHIFT, 64'(SHIFT_MAX));
    w.address = (64'(MapWords * 64 - 1) << SHIFT_MAX) | 64'hFFFF;
    queue_lookup(w);
    w.address = 64'hFFFF_FFFF_FFFF_FFFF;
    queue_lookup(w);
    w.opcode = OP_CLEAR;
    queue_lookup(w);
    w.opcode  = OP_TRANSLATE;
    w.address = 64'd0;
    queue_lookup(w);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
